/* rtl/core/sts_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted table search package
// Shared constants, controller/datapath command and status types, helpers.
// ----------------------------------------------------------------------------
package sts_pkg;

	// Table geometry.
	localparam int DEPTH      = 1024;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Fixed field widths of the request and response channels.
	localparam int IDX_W   = 10;
	localparam int FIELD_W = 32;

	// Working widths for index and value conversions.
	localparam int PW = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
	localparam int VW = (DATA_WIDTH > FIELD_W) ? DATA_WIDTH : FIELD_W;

	// Request action codes.
	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_SEARCH = 1'b1;

	// Read address selection.
	typedef enum logic [1:0] {
		RD_HI   = 2'd0,
		RD_LO   = 2'd1,
		RD_INIT = 2'd2,
		RD_NEXT = 2'd3
	} sts_rd_sel_t;

	// Result register update.
	typedef enum logic [2:0] {
		RES_NONE  = 3'd0,
		RES_MISS  = 3'd1,
		RES_HI    = 3'd2,
		RES_LO    = 3'd3,
		RES_PROBE = 3'd4
	} sts_res_t;

	// Controller state, one-hot.
	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_DISPATCH = 6'b000010,
		S_RD_HI    = 6'b000100,
		S_RD_LO    = 6'b001000,
		S_PROBE    = 6'b010000,
		S_DONE     = 6'b100000
	} sts_state_t;

	typedef struct packed {
		logic        load_req;
		logic        mem_wr;
		logic        rd_en;
		sts_rd_sel_t rd_sel;
		logic        hi_flag_load;
		logic        probe_init;
		logic        probe_step;
		sts_res_t    res;
		logic        out_load;
	} sts_cmd_t;

	typedef struct packed {
		logic is_write;
		logic in_table;
		logic range_ok;
		logic eq;
		logic rdata_before;
		logic hi_flag;
		logic step_zero;
	} sts_status_t;

	function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] i);
		logic [PW-1:0] w;
		w = PW'(i);
		return w[ADDR_W-1:0];
	endfunction

	function automatic logic idx_in_table(input logic [IDX_W-1:0] i);
		return (PW+1)'(i) < (PW+1)'(DEPTH);
	endfunction

	function automatic logic [DATA_WIDTH-1:0] to_val(input logic [FIELD_W-1:0] v);
		logic [VW-1:0] w;
		w = VW'(v);
		return w[DATA_WIDTH-1:0];
	endfunction

endpackage

/* rtl/core/sts_if.sv */
// ----------------------------------------------------------------------------
// Sorted table search channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sts_req_if;
	logic                       valid;
	logic                       ready;
	logic                       action;
	logic [sts_pkg::IDX_W-1:0]   entry_index;
	logic [sts_pkg::FIELD_W-1:0] entry_value;
	logic [sts_pkg::FIELD_W-1:0] needle;
	logic [sts_pkg::IDX_W-1:0]   range_low;
	logic [sts_pkg::IDX_W-1:0]   range_high;

	modport source (
		output valid, action, entry_index, entry_value, needle, range_low, range_high,
		input  ready
	);
	modport sink (
		input  valid, action, entry_index, entry_value, needle, range_low, range_high,
		output ready
	);
endinterface

interface sts_rsp_if;
	logic                     valid;
	logic                     ready;
	logic                     found;
	logic [sts_pkg::IDX_W-1:0] position;

	modport source (
		output valid, found, position,
		input  ready
	);
	modport sink (
		input  valid, found, position,
		output ready
	);
endinterface

/* rtl/core/sts_ctrl.sv */
// ----------------------------------------------------------------------------
// Sorted table search controller
// Sequences request dispatch, boundary reads, probe steps and response output.
// ----------------------------------------------------------------------------
module sts_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sts_pkg::sts_cmd_t    cmd,
	input  sts_pkg::sts_status_t sts
);
	import sts_pkg::*;

	sts_state_t state_q;
	sts_state_t state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		cmd.res = RES_NONE;
		cmd.rd_sel = RD_HI;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (sts.is_write) begin
					cmd.mem_wr = sts.in_table;
					cmd.res    = RES_MISS;
					state_d    = S_DONE;
				end else if (!sts.range_ok) begin
					cmd.res = RES_MISS;
					state_d = S_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_HI;
					state_d    = S_RD_HI;
				end
			end
			S_RD_HI: begin
				if (sts.eq) begin
					cmd.res = RES_HI;
					state_d = S_DONE;
				end else begin
					cmd.hi_flag_load = 1'b1;
					cmd.rd_en        = 1'b1;
					cmd.rd_sel       = RD_LO;
					state_d          = S_RD_LO;
				end
			end
			S_RD_LO: begin
				if (sts.rdata_before && sts.hi_flag) begin
					cmd.probe_init = 1'b1;
					cmd.rd_en      = 1'b1;
					cmd.rd_sel     = RD_INIT;
					state_d        = S_PROBE;
				end else begin
					cmd.res = sts.eq ? RES_LO : RES_MISS;
					state_d = S_DONE;
				end
			end
			S_PROBE: begin
				if (sts.eq) begin
					cmd.res = RES_PROBE;
					state_d = S_DONE;
				end else if (sts.step_zero) begin
					cmd.res = RES_MISS;
					state_d = S_DONE;
				end else begin
					cmd.probe_step = 1'b1;
					cmd.rd_en      = 1'b1;
					cmd.rd_sel     = RD_NEXT;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_DISPATCH))
		else $error("accepted request did not enter dispatch");

	a_done_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !out_valid_q) |=> (state_q == S_IDLE && out_valid_q))
		else $error("finished result not moved to the free output register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !cmd.out_load)
		else $error("output register overwritten while stalled");
`endif

endmodule

/* rtl/core/sts_dp.sv */
// ----------------------------------------------------------------------------
// Sorted table search datapath
// Table memory, request registers, compare logic, probe index and gap.
// ----------------------------------------------------------------------------
module sts_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_wdata,
	input  logic                         action,
	input  logic [sts_pkg::IDX_W-1:0]    entry_index,
	input  logic [sts_pkg::FIELD_W-1:0]  entry_value,
	input  logic [sts_pkg::FIELD_W-1:0]  needle,
	input  logic [sts_pkg::IDX_W-1:0]    range_low,
	input  logic [sts_pkg::IDX_W-1:0]    range_high,
	input  sts_pkg::sts_cmd_t            cmd,
	output sts_pkg::sts_status_t         sts,
	output logic                         found,
	output logic [sts_pkg::IDX_W-1:0]    position
);
	import sts_pkg::*;

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	logic                  descending_q;
	logic                  action_q;
	logic [IDX_W-1:0]      idx_q;
	logic [DATA_WIDTH-1:0] value_q;
	logic [DATA_WIDTH-1:0] needle_q;
	logic [IDX_W-1:0]      lo_q;
	logic [IDX_W-1:0]      hi_q;
	logic                  hi_flag_q;
	logic [IDX_W-1:0]      p_q;
	logic [IDX_W-1:0]      gap_q;
	logic                  res_found_q;
	logic [IDX_W-1:0]      res_pos_q;
	logic                  found_q;
	logic [IDX_W-1:0]      position_q;

	logic                  rd_lt;
	logic                  rd_gt;
	logic                  needle_before;
	logic [IDX_W-1:0]      step;
	logic [IDX_W-1:0]      room_up;
	logic [IDX_W-1:0]      room_dn;
	logic [IDX_W-1:0]      p_next;
	logic [IDX_W:0]        gap_inc;
	logic [IDX_W-1:0]      rd_idx;

	// Compare the word just read against the needle in table order.
	assign rd_lt         = rdata_q < needle_q;
	assign rd_gt         = rdata_q > needle_q;
	assign needle_before = descending_q ? rd_lt : rd_gt;

	assign sts.is_write     = (action_q == ACT_WRITE);
	assign sts.in_table     = idx_in_table(idx_q);
	assign sts.range_ok     = (lo_q <= hi_q) && idx_in_table(hi_q);
	assign sts.eq           = (rdata_q == needle_q);
	assign sts.rdata_before = descending_q ? rd_gt : rd_lt;
	assign sts.hi_flag      = hi_flag_q;
	assign sts.step_zero    = (step == '0);

	// Probe move, saturated to the search range.
	assign step    = gap_q >> 1;
	assign room_up = hi_q - p_q;
	assign room_dn = p_q - lo_q;
	assign gap_inc = {1'b0, gap_q} + (IDX_W+1)'(1);

	always_comb begin
		if (sts.rdata_before) begin
			p_next = (step > room_up) ? hi_q : p_q + step;
		end else begin
			p_next = (step > room_dn) ? lo_q : p_q - step;
		end
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_HI:   rd_idx = hi_q;
			RD_LO:   rd_idx = lo_q;
			RD_INIT: rd_idx = hi_q - IDX_W'(1);
			RD_NEXT: rd_idx = p_next;
			default: rd_idx = hi_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			mem[to_addr(idx_q)] <= value_q;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[to_addr(rd_idx)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			descending_q <= 1'b0;
		end else if (cfg_we) begin
			descending_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			action_q <= action;
			idx_q    <= entry_index;
			value_q  <= to_val(entry_value);
			needle_q <= to_val(needle);
			lo_q     <= range_low;
			hi_q     <= range_high;
		end
		if (cmd.hi_flag_load) begin
			hi_flag_q <= needle_before;
		end
		if (cmd.probe_init) begin
			p_q   <= hi_q - IDX_W'(1);
			gap_q <= hi_q - lo_q - IDX_W'(1);
		end else if (cmd.probe_step) begin
			p_q   <= p_next;
			gap_q <= gap_inc[IDX_W:1];
		end
		case (cmd.res)
			RES_MISS: begin
				res_found_q <= 1'b0;
				res_pos_q   <= '0;
			end
			RES_HI: begin
				res_found_q <= 1'b1;
				res_pos_q   <= hi_q;
			end
			RES_LO: begin
				res_found_q <= 1'b1;
				res_pos_q   <= lo_q;
			end
			RES_PROBE: begin
				res_found_q <= 1'b1;
				res_pos_q   <= p_q;
			end
			default: begin
			end
		endcase
		if (cmd.out_load) begin
			found_q    <= res_found_q;
			position_q <= res_pos_q;
		end
	end

	assign found    = found_q;
	assign position = position_q;

`ifndef ASSERT_OFF
	a_probe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.probe_step |=> (p_q >= lo_q && p_q <= hi_q))
		else $error("probe index left the search range");

	a_gap_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.probe_step |=> (gap_q < $past(gap_q)))
		else $error("probe gap did not shrink");
`endif

endmodule

/* rtl/core/sorted_table_search.sv */
// ----------------------------------------------------------------------------
// Sorted table search
// Table of words with single-entry writes and range-limited probe search.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req. A write request (action = 0) stores
// entry_value at entry_index; a search request (action = 1) looks for needle
// between range_low and range_high inclusive. Every request yields exactly one
// response on rsp: found and position for a hit, zero for a miss or a write.
// The single register descending_q is written through cfg_we/cfg_wdata and
// selects ascending (0) or descending (1) order; the user must write it only
// while the block is idle, which the block itself does not enforce.
// A write or a rejected range goes from dispatch directly to done. A search
// reads the top entry, then the bottom entry, then runs one probe per cycle on
// the single table read port, one probe per gap halving. A hit on the top entry
// ends the search; otherwise the bottom entry decides unless the needle lies
// between the two, and then the probes run. A full 1024-entry range needs at
// most 11 probes. The controller returns to idle as the response register
// loads, and it takes no new request before then.
// A finished response waits in the output register, so the next request is
// accepted while the receiver stalls. Reset clears the controller, the output
// valid and the order register; the table itself is not cleared and entries
// must be written before they are searched.
// ----------------------------------------------------------------------------
module sorted_table_search (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	sts_req_if.sink   req,
	sts_rsp_if.source rsp
);
	import sts_pkg::*;

	// Command and status bundles between the controller and the datapath.
	sts_cmd_t    cmd;
	sts_status_t sts;

	// The controller owns both handshakes and the sequencing of memory reads.
	sts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// The datapath holds the table, the captured request, the probe state and
	// the response register that drives the rsp payload.
	sts_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.action      (req.action),
		.entry_index (req.entry_index),
		.entry_value (req.entry_value),
		.needle      (req.needle),
		.range_low   (req.range_low),
		.range_high  (req.range_high),
		.cmd         (cmd),
		.sts         (sts),
		.found       (rsp.found),
		.position    (rsp.position)
	);

endmodule
